FILE: sv/ssha_pkg.sv
// Shared types and constants for the sparse-set handle allocator.
// No dependencies; imported by ssha_tables and sparse_set_handle_allocator.
`default_nettype none

package ssha_pkg;

	localparam int CAPACITY = 256;
	localparam int HANDLE_W = 8;
	localparam int COUNT_W  = 9;

	localparam logic [1:0] ACT_ALLOC  = 2'd0;
	localparam logic [1:0] ACT_FREE   = 2'd1;
	localparam logic [1:0] ACT_LOOKUP = 2'd2;

	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_FULL    = 2'd1;
	localparam logic [1:0] ST_INVALID = 2'd2;

	typedef struct packed {
		logic [1:0]          action;
		logic [HANDLE_W-1:0] handle_in;
	} req_t;

	typedef struct packed {
		logic [1:0]          status;
		logic [HANDLE_W-1:0] handle_out;
		logic [HANDLE_W-1:0] dense_position;
		logic                moved_flag;
		logic [HANDLE_W-1:0] moved_handle;
		logic [COUNT_W-1:0]  live_count;
	} rsp_t;

	// Read request to the tables: one address per memory, all issued together.
	typedef struct packed {
		logic                rd;
		logic [HANDLE_W-1:0] fs_addr;
		logic [HANDLE_W-1:0] pos_addr;
		logic [HANDLE_W-1:0] ham_addr;
	} tbl_rd_t;

	// Write request to the tables: one write port per memory plus the live bits.
	typedef struct packed {
		logic                fs_we;
		logic [HANDLE_W-1:0] fs_waddr;
		logic [HANDLE_W-1:0] fs_wdata;
		logic                pos_we;
		logic [HANDLE_W-1:0] pos_waddr;
		logic [HANDLE_W-1:0] pos_wdata;
		logic                ham_we;
		logic [HANDLE_W-1:0] ham_waddr;
		logic [HANDLE_W-1:0] ham_wdata;
		logic                live_we;
		logic [HANDLE_W-1:0] live_addr;
		logic                live_val;
	} tbl_wr_t;

	// Read data, valid in the cycle after the read request.
	typedef struct packed {
		logic [HANDLE_W-1:0] fs_data;
		logic [HANDLE_W-1:0] pos_data;
		logic [HANDLE_W-1:0] ham_data;
		logic                live;
	} tbl_rsp_t;

endpackage

`default_nettype wire

FILE: sv/ssha_tables.sv
// Storage of the handle allocator: free stack, handle-to-position map,
// position-to-handle list and per-handle live bits. Uses ssha_pkg.
`default_nettype none

module ssha_tables
	import ssha_pkg::*;
(
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire tbl_rd_t  rd_req,
	input  wire tbl_wr_t  wr_req,
	output tbl_rsp_t      rd_rsp
);

	logic [HANDLE_W-1:0] fs_mem  [CAPACITY];
	logic [HANDLE_W-1:0] pos_mem [CAPACITY];
	logic [HANDLE_W-1:0] ham_mem [CAPACITY];

	// Lowest free stack entry written so far. The stack top only moves one entry at a time,
	// so every entry at or above it has been written and every entry below it
	// still holds its reset value, its own index.
	logic [COUNT_W-1:0]  fs_low_q;
	// Live bit per handle; a clear bit stands for the unassigned map entry.
	logic [CAPACITY-1:0] live_q;

	logic [HANDLE_W-1:0] fs_rd_q;
	logic [HANDLE_W-1:0] fs_idx_q;
	logic                fs_hit_q;
	logic [HANDLE_W-1:0] pos_rd_q;
	logic [HANDLE_W-1:0] ham_rd_q;
	logic                live_rd_q;

	always_ff @(posedge clk) begin
		if (wr_req.fs_we) begin
			fs_mem[wr_req.fs_waddr] <= wr_req.fs_wdata;
		end
		if (rd_req.rd) begin
			fs_rd_q  <= fs_mem[rd_req.fs_addr];
			fs_idx_q <= rd_req.fs_addr;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_req.pos_we) begin
			pos_mem[wr_req.pos_waddr] <= wr_req.pos_wdata;
		end
		if (rd_req.rd) begin
			pos_rd_q <= pos_mem[rd_req.pos_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (wr_req.ham_we) begin
			ham_mem[wr_req.ham_waddr] <= wr_req.ham_wdata;
		end
		if (rd_req.rd) begin
			ham_rd_q <= ham_mem[rd_req.ham_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fs_low_q  <= COUNT_W'(CAPACITY);
			live_q    <= '0;
			fs_hit_q  <= 1'b0;
			live_rd_q <= 1'b0;
		end else begin
			if (wr_req.fs_we && ({1'b0, wr_req.fs_waddr} < fs_low_q)) begin
				fs_low_q <= {1'b0, wr_req.fs_waddr};
			end
			if (wr_req.live_we) begin
				live_q[wr_req.live_addr] <= wr_req.live_val;
			end
			if (rd_req.rd) begin
				fs_hit_q  <= ({1'b0, rd_req.fs_addr} >= fs_low_q);
				live_rd_q <= live_q[rd_req.pos_addr];
			end
		end
	end

	assign rd_rsp.fs_data  = fs_hit_q ? fs_rd_q : fs_idx_q;
	assign rd_rsp.pos_data = pos_rd_q;
	assign rd_rsp.ham_data = ham_rd_q;
	assign rd_rsp.live     = live_rd_q;

endmodule

`default_nettype wire

FILE: sv/sparse_set_handle_allocator.sv
// Sparse-set handle allocator with a free stack, top level.
// Uses ssha_pkg and ssha_tables.
//
// Usage: send one request word on req (req_valid/req_stall): allocate, free
// or look up a handle. Each request returns exactly one response word on rsp
// (rsp_valid/rsp_stall) with status, allocated handle, dense slot, the handle
// moved by a free and the live count after the request.
// Sequence: the accept cycle registers the request and issues the reads of
// the three tables; the write-back state takes the registered read data,
// writes the tables back and loads the response register. The block takes
// one request at a time, so no access to a table entry overlaps another.
// Stall: while rsp_stall holds a response, the next request is still accepted
// and its table reads are done; its write-back waits until the response
// register is free, and req_stall stays high meanwhile.
// Reset: arst_n clears all handles to free (the first allocate yields the
// highest handle), the live count to zero and drops any pending response.
// No clearing pass is needed; a low-water mark of the free stack writes and
// a live bit per handle stand in for table reset.
// Allocate when full answers status full; free or lookup of a handle that is
// not live, and an unknown action, answer status invalid and change nothing.
`default_nettype none

module sparse_set_handle_allocator
	import ssha_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic req_valid,
	output logic      req_stall,
	input  wire req_t req,
	output logic      rsp_valid,
	input  wire logic rsp_stall,
	output rsp_t      rsp
);

	typedef enum logic {
		S_IDLE,
		S_WB
	} state_t;

	state_t               state_q;
	logic [1:0]           act_q;
	logic [HANDLE_W-1:0]  h_q;
	logic [COUNT_W-1:0]   used_q;
	logic [COUNT_W-1:0]   used_d;
	logic [COUNT_W-1:0]   last;
	rsp_t                 rsp_q;
	rsp_t                 rsp_d;
	logic                 rsp_valid_q;
	logic                 accept;
	logic                 out_free;
	logic                 commit;
	tbl_rd_t              tbl_rd;
	tbl_wr_t              wr_d;
	tbl_wr_t              tbl_wr;
	tbl_rsp_t             tbl_rsp;

	assign req_stall = (state_q != S_IDLE);
	assign accept    = req_valid && !req_stall;
	assign out_free  = !rsp_valid_q || !rsp_stall;
	assign commit    = (state_q == S_WB) && out_free;
	assign last      = used_q - COUNT_W'(1);

	// Issue all reads at accept; the free stack top and the last dense slot
	// depend only on the live count, the map entry on the request handle.
	always_comb begin
		tbl_rd.rd       = accept;
		tbl_rd.fs_addr  = HANDLE_W'(CAPACITY - 1) - used_q[HANDLE_W-1:0];
		tbl_rd.pos_addr = req.handle_in;
		tbl_rd.ham_addr = last[HANDLE_W-1:0];
	end

	ssha_tables u_tables (
		.clk    (clk),
		.arst_n (arst_n),
		.rd_req (tbl_rd),
		.wr_req (tbl_wr),
		.rd_rsp (tbl_rsp)
	);

	always_comb begin
		rsp_d            = '0;
		rsp_d.status     = ST_INVALID;
		rsp_d.live_count = used_q;
		used_d           = used_q;
		wr_d             = '0;
		case (act_q)
			ACT_ALLOC: begin
				if (used_q >= COUNT_W'(CAPACITY)) begin
					rsp_d.status = ST_FULL;
				end else begin
					wr_d.pos_we          = 1'b1;
					wr_d.pos_waddr       = tbl_rsp.fs_data;
					wr_d.pos_wdata       = used_q[HANDLE_W-1:0];
					wr_d.ham_we          = 1'b1;
					wr_d.ham_waddr       = used_q[HANDLE_W-1:0];
					wr_d.ham_wdata       = tbl_rsp.fs_data;
					wr_d.live_we         = 1'b1;
					wr_d.live_addr       = tbl_rsp.fs_data;
					wr_d.live_val        = 1'b1;
					used_d               = used_q + COUNT_W'(1);
					rsp_d.status         = ST_OK;
					rsp_d.handle_out     = tbl_rsp.fs_data;
					rsp_d.dense_position = used_q[HANDLE_W-1:0];
					rsp_d.live_count     = used_d;
				end
			end
			ACT_FREE: begin
				if (tbl_rsp.live) begin
					// Swap-remove: move the last dense entry into the hole.
					if (tbl_rsp.pos_data != last[HANDLE_W-1:0]) begin
						wr_d.ham_we        = 1'b1;
						wr_d.ham_waddr     = tbl_rsp.pos_data;
						wr_d.ham_wdata     = tbl_rsp.ham_data;
						wr_d.pos_we        = 1'b1;
						wr_d.pos_waddr     = tbl_rsp.ham_data;
						wr_d.pos_wdata     = tbl_rsp.pos_data;
						rsp_d.moved_flag   = 1'b1;
						rsp_d.moved_handle = tbl_rsp.ham_data;
					end
					wr_d.live_we     = 1'b1;
					wr_d.live_addr   = h_q;
					wr_d.live_val    = 1'b0;
					wr_d.fs_we       = 1'b1;
					wr_d.fs_waddr    = HANDLE_W'(CAPACITY - 1) - last[HANDLE_W-1:0];
					wr_d.fs_wdata    = h_q;
					used_d           = last;
					rsp_d.status     = ST_OK;
					rsp_d.live_count = last;
				end
			end
			ACT_LOOKUP: begin
				if (tbl_rsp.live) begin
					rsp_d.status         = ST_OK;
					rsp_d.dense_position = tbl_rsp.pos_data;
				end
			end
			default: begin
			end
		endcase
	end

	assign tbl_wr = commit ? wr_d : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			used_q      <= '0;
			rsp_valid_q <= 1'b0;
			act_q       <= ACT_ALLOC;
			h_q         <= '0;
			rsp_q       <= '0;
		end else begin
			if (commit) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						act_q   <= req.action;
						h_q     <= req.handle_in;
						state_q <= S_WB;
					end
				end
				S_WB: begin
					// Hold until the response register can take the word.
					if (out_free) begin
						used_q  <= used_d;
						rsp_q   <= rsp_d;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	a_used_bound: assert property (@(posedge clk) disable iff (!arst_n)
		used_q <= COUNT_W'(CAPACITY))
		else $error("live count above capacity");

	a_alloc_count: assert property (@(posedge clk) disable iff (!arst_n)
		commit && act_q == ACT_ALLOC && rsp_d.status == ST_OK
		|=> used_q == $past(used_q) + COUNT_W'(1))
		else $error("allocate did not advance live count");

	a_full_count: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.status == ST_FULL |-> rsp.live_count == COUNT_W'(CAPACITY))
		else $error("full status below capacity");

	a_move_ok: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.moved_flag |-> rsp.status == ST_OK)
		else $error("move reported on failed request");

	a_free_hold: assert property (@(posedge clk) disable iff (!arst_n)
		commit && rsp_d.status != ST_OK |=> used_q == $past(used_q))
		else $error("failed request changed live count");

endmodule

`default_nettype wire
